[rtl/fasta_index_scanner_defines.svh]
// assertion helpers shared by the scanner rtl
`ifndef FASTA_INDEX_SCANNER_DEFINES_SVH
`define FASTA_INDEX_SCANNER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define FIS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define FIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fis_pkg.sv]
`default_nettype none

package fis_pkg;

  localparam int OFFSET_BITS = 40;
  localparam int NAME_BITS   = 16;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [NAME_BITS-1:0]   NAME_MAX   = {NAME_BITS{1'b1}};

  localparam logic [7:0] HDR_CHAR   = 8'h3E;
  localparam logic [7:0] NL_CHAR    = 8'h0A;
  localparam logic [7:0] WS_LO      = 8'd9;
  localparam logic [7:0] WS_HI      = 8'd13;
  localparam logic [7:0] SPACE_CHAR = 8'd32;
  localparam logic [7:0] PRINT_LO   = 8'd33;
  localparam logic [7:0] PRINT_HI   = 8'd126;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_EMPTY_SEQ  = 2'd2,
    ST_UNEVEN     = 2'd3
  } status_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] name_start;
    logic [NAME_BITS-1:0]   name_length;
    logic [OFFSET_BITS-1:0] seq_offset;
    logic [OFFSET_BITS-1:0] seq_length;
    logic [OFFSET_BITS-1:0] line_bases;
    logic [OFFSET_BITS-1:0] line_bytes;
    status_t                status;
  } record_t;

  typedef struct packed {
    logic    valid;
    record_t rec;
  } scan_result_t;

  function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
    return (v != OFFSET_MAX) ? v + OFFSET_BITS'(1) : v;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return ((b >= WS_LO) && (b <= WS_HI)) || (b == SPACE_CHAR);
  endfunction

  function automatic logic is_print(input logic [7:0] b);
    return (b >= PRINT_LO) && (b <= PRINT_HI);
  endfunction

endpackage

`default_nettype wire

[rtl/fis_scan.sv]
`default_nettype none

`include "fasta_index_scanner_defines.svh"

module fis_scan (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step_en,
  input  wire logic [7:0]           step_byte,
  input  wire logic                 step_last,
  output fis_pkg::scan_result_t     result
);
  import fis_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER     = 3'd0,
    PH_NAME       = 3'd1,
    PH_COMMENT    = 3'd2,
    PH_SEEK       = 3'd3,
    PH_FIRST_LINE = 3'd4,
    PH_FIRST_GAP  = 3'd5,
    PH_LINE       = 3'd6,
    PH_GAP        = 3'd7
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] name_start_r, name_start_nxt;
  logic [NAME_BITS-1:0]   name_len_r, name_len_nxt;
  logic [OFFSET_BITS-1:0] seq_off_r, seq_off_nxt;
  logic [OFFSET_BITS-1:0] seq_len_r, seq_len_nxt;
  logic [OFFSET_BITS-1:0] line_bases_r, line_bases_nxt;
  logic [OFFSET_BITS-1:0] line_bytes_r, line_bytes_nxt;
  logic [OFFSET_BITS-1:0] cur_len_r, cur_len_nxt;
  logic                   short_r, short_nxt;
  logic                   err_r, err_nxt;

  logic    emit;
  logic    halt;
  record_t rec;
  record_t held;
  logic    ws;
  logic    pr;
  logic    hdr;

  assign ws  = is_ws(step_byte);
  assign pr  = is_print(step_byte);
  assign hdr = (step_byte == HDR_CHAR);

  always_comb begin
    held = '{name_start:  name_start_r,
             name_length: name_len_r,
             seq_offset:  seq_off_r,
             seq_length:  seq_len_r,
             line_bases:  line_bases_r,
             line_bytes:  line_bytes_r,
             status:      ST_OK};
  end

  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    name_start_nxt = name_start_r;
    name_len_nxt   = name_len_r;
    seq_off_nxt    = seq_off_r;
    seq_len_nxt    = seq_len_r;
    line_bases_nxt = line_bases_r;
    line_bytes_nxt = line_bytes_r;
    cur_len_nxt    = cur_len_r;
    short_nxt      = short_r;
    err_nxt        = err_r;
    emit           = 1'b0;
    halt           = 1'b0;
    rec            = held;

    if (!err_r) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (!hdr) begin
            rec        = '0;
            rec.status = ST_BAD_HEADER;
            emit       = 1'b1;
            halt       = 1'b1;
            err_nxt    = 1'b1;
          end else begin
            name_start_nxt = sat_inc(pos_r);
            name_len_nxt   = '0;
            seq_off_nxt    = '0;
            seq_len_nxt    = '0;
            line_bases_nxt = '0;
            line_bytes_nxt = '0;
            cur_len_nxt    = '0;
            short_nxt      = 1'b0;
            phase_nxt      = PH_NAME;
          end
        end
        PH_NAME: begin
          if (!ws) begin
            if (name_len_r != NAME_MAX) name_len_nxt = name_len_r + NAME_BITS'(1);
          end else begin
            phase_nxt = (step_byte == NL_CHAR) ? PH_SEEK : PH_COMMENT;
          end
        end
        PH_COMMENT: begin
          if (step_byte == NL_CHAR) phase_nxt = PH_SEEK;
        end
        PH_SEEK: begin
          if (pr) begin
            seq_off_nxt = pos_r;
            if (hdr) begin
              rec.seq_offset = pos_r;
              rec.status     = ST_EMPTY_SEQ;
              emit           = 1'b1;
              halt           = 1'b1;
              err_nxt        = 1'b1;
            end else begin
              seq_len_nxt    = OFFSET_BITS'(1);
              line_bases_nxt = OFFSET_BITS'(1);
              line_bytes_nxt = OFFSET_BITS'(1);
              phase_nxt      = PH_FIRST_LINE;
            end
          end
        end
        PH_FIRST_LINE: begin
          if (!ws) begin
            line_bases_nxt = sat_inc(line_bases_r);
            seq_len_nxt    = sat_inc(seq_len_r);
          end else begin
            phase_nxt = PH_FIRST_GAP;
          end
          line_bytes_nxt = sat_inc(line_bytes_r);
        end
        PH_FIRST_GAP: begin
          if (ws) begin
            line_bytes_nxt = sat_inc(line_bytes_r);
          end else if (hdr) begin
            // close this record and open the next header
            emit           = 1'b1;
            name_start_nxt = sat_inc(pos_r);
            name_len_nxt   = '0;
            seq_off_nxt    = '0;
            seq_len_nxt    = '0;
            line_bases_nxt = '0;
            line_bytes_nxt = '0;
            cur_len_nxt    = '0;
            short_nxt      = 1'b0;
            phase_nxt      = PH_NAME;
          end else begin
            cur_len_nxt = OFFSET_BITS'(1);
            seq_len_nxt = sat_inc(seq_len_r);
            phase_nxt   = PH_LINE;
          end
        end
        PH_LINE: begin
          if (!ws) begin
            cur_len_nxt = sat_inc(cur_len_r);
            seq_len_nxt = sat_inc(seq_len_r);
          end else begin
            if (cur_len_r != line_bases_r) short_nxt = 1'b1;
            phase_nxt = PH_GAP;
          end
        end
        PH_GAP: begin
          if (pr) begin
            if (hdr) begin
              emit           = 1'b1;
              name_start_nxt = sat_inc(pos_r);
              name_len_nxt   = '0;
              seq_off_nxt    = '0;
              seq_len_nxt    = '0;
              line_bases_nxt = '0;
              line_bytes_nxt = '0;
              cur_len_nxt    = '0;
              short_nxt      = 1'b0;
              phase_nxt      = PH_NAME;
            end else if (short_r) begin
              // a short line was not the last one
              rec.status = ST_UNEVEN;
              emit       = 1'b1;
              halt       = 1'b1;
              err_nxt    = 1'b1;
            end else begin
              cur_len_nxt = OFFSET_BITS'(1);
              seq_len_nxt = sat_inc(seq_len_r);
              phase_nxt   = PH_LINE;
            end
          end
        end
      endcase

      if (!halt) begin
        if (step_last) begin
          if (!emit) begin
            emit = 1'b1;
            rec  = '{name_start:  name_start_nxt,
                     name_length: name_len_nxt,
                     seq_offset:  seq_off_nxt,
                     seq_length:  seq_len_nxt,
                     line_bases:  line_bases_nxt,
                     line_bytes:  line_bytes_nxt,
                     status:      ST_OK};
            // file ended before any base
            if (phase_nxt == PH_NAME || phase_nxt == PH_COMMENT || phase_nxt == PH_SEEK)
              rec.seq_offset = sat_inc(pos_r);
          end
          phase_nxt      = PH_HEADER;
          pos_nxt        = '0;
          name_start_nxt = '0;
          name_len_nxt   = '0;
          seq_off_nxt    = '0;
          seq_len_nxt    = '0;
          line_bases_nxt = '0;
          line_bytes_nxt = '0;
          cur_len_nxt    = '0;
          short_nxt      = 1'b0;
        end else begin
          pos_nxt = sat_inc(pos_r);
        end
      end
    end
  end

  assign result.valid = step_en && emit;
  assign result.rec   = rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      pos_r        <= '0;
      name_start_r <= '0;
      name_len_r   <= '0;
      seq_off_r    <= '0;
      seq_len_r    <= '0;
      line_bases_r <= '0;
      line_bytes_r <= '0;
      cur_len_r    <= '0;
      short_r      <= 1'b0;
      err_r        <= 1'b0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      name_start_r <= name_start_nxt;
      name_len_r   <= name_len_nxt;
      seq_off_r    <= seq_off_nxt;
      seq_len_r    <= seq_len_nxt;
      line_bases_r <= line_bases_nxt;
      line_bytes_r <= line_bytes_nxt;
      cur_len_r    <= cur_len_nxt;
      short_r      <= short_nxt;
      err_r        <= err_nxt;
    end
  end

  `FIS_ASSERT_NEXT(a_err_sticky, clk, rst_n, err_r, err_r, "error flag dropped without reset")
  `FIS_ASSERT_IMPL(a_err_quiet, clk, rst_n, err_r, !result.valid, "record after latched error")
  `FIS_ASSERT_NEXT(a_last_rewinds, clk, rst_n, step_en && step_last && !err_r && !halt,
                   pos_r == '0 && phase_r == PH_HEADER, "final byte did not rewind the parser")

endmodule

`default_nettype wire

[rtl/fasta_index_scanner.sv]
`default_nettype none
// fasta index scanner
// input channel: one file byte per transfer on in_data_byte, with in_last_byte
// high on the final byte of a file; in_valid / in_stall handshake
// output channel: one index record per sequence on the out_ ports, with
// out_status giving ok, bad header start, empty sequence or uneven lines
// throughput: one byte per cycle while no held record stalls the input; the parser
// state update in the scan stage is a loop of compares and saturating increments
// a record reaches the output from the byte transfer that closes it through the
// input register, then the scan and result register
// a new file may follow the final byte directly, the parser rewinds itself
// after an error record, every later byte is taken and dropped until reset
// reset: synchronous, active low; clears the valid flags of both pipeline registers
// and the parser, the block is ready in the cycle after reset is released
// stall: a held record stays on the output until taken; the byte in the
// input register waits with it, so in_stall rises in that same cycle

`include "fasta_index_scanner_defines.svh"

module fasta_index_scanner (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      in_data_byte,
  input  wire logic                            in_last_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [fis_pkg::OFFSET_BITS-1:0]      out_name_start,
  output logic [fis_pkg::NAME_BITS-1:0]        out_name_length,
  output logic [fis_pkg::OFFSET_BITS-1:0]      out_seq_offset,
  output logic [fis_pkg::OFFSET_BITS-1:0]      out_seq_length,
  output logic [fis_pkg::OFFSET_BITS-1:0]      out_line_bases,
  output logic [fis_pkg::OFFSET_BITS-1:0]      out_line_bytes,
  output logic [1:0]                           out_status
);
  import fis_pkg::*;

  logic         in_valid_r;
  logic [7:0]   in_byte_r;
  logic         in_last_r;
  logic         out_valid_r;
  record_t      out_rec_r;
  logic         out_free;
  logic         step;
  scan_result_t res;

  assign out_free = !out_valid_r || !out_stall;
  assign step     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  fis_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step),
    .step_byte (in_byte_r),
    .step_last (in_last_r),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) in_valid_r <= in_valid;
      if (out_free) out_valid_r <= step && res.valid;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
    if (step && res.valid) out_rec_r <= res.rec;
  end

  assign out_valid       = out_valid_r;
  assign out_name_start  = out_rec_r.name_start;
  assign out_name_length = out_rec_r.name_length;
  assign out_seq_offset  = out_rec_r.seq_offset;
  assign out_seq_length  = out_rec_r.seq_length;
  assign out_line_bases  = out_rec_r.line_bases;
  assign out_line_bytes  = out_rec_r.line_bytes;
  assign out_status      = out_rec_r.status;

  `FIS_ASSERT_NEXT(a_rec_loaded, clk, rst_n, step && res.valid, out_valid_r,
                   "record transfer lost in result register")
  `FIS_ASSERT_IMPL(a_stall_held, clk, rst_n, in_stall, in_valid_r && out_valid_r,
                   "input stalled with free pipeline")
  `FIS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && out_stall,
                   out_valid_r && $stable(out_rec_r), "stalled record changed")

endmodule

`default_nettype wire
